[hdl/composite_key_deframer_macros.svh]
// Assertion macros for the composite key deframer checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef COMPOSITE_KEY_DEFRAMER_MACROS_SVH
`define COMPOSITE_KEY_DEFRAMER_MACROS_SVH

// Same-cycle implication, reset masked
`define CKD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("composite_key_deframer assertion failed");

// Next-cycle implication, reset masked
`define CKD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("composite_key_deframer assertion failed");

`endif

[hdl/ckd_pkg.sv]
// Shared types and constants for the composite key deframer.
// No dependencies; used by every module of the block but the input register.
package ckd_pkg;

  // Default width of a component length prefix
  localparam int LENGTH_BITS_DEF = 16;

  // Error codes carried on each result transaction
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAD_MARK  = 2'd1,
    ERR_TRUNCATED = 2'd2
  } err_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       component_end;
    logic [7:0] end_marker;
    err_t       error_code;
    logic       key_end;
  } res_t;

endpackage

[hdl/ckd_in_stage.sv]
// Input register of the composite key deframer: holds one key byte transaction.
// Depends on nothing but the ports; the top level decides when it advances.
module ckd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_key_byte,
  input  logic       in_key_last,
  input  logic       advance,
  output logic       item_vld,
  output logic [7:0] item_byte,
  output logic       item_last
);

  logic       vld_r;
  logic [7:0] byte_r;
  logic       last_r;

  // Stall only while a held byte cannot move on
  assign in_stall  = vld_r && !advance;
  assign item_vld  = vld_r;
  assign item_byte = byte_r;
  assign item_last = last_r;

  // Take a new transaction whenever the register is free or draining
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_key_byte;
      last_r <= in_key_last;
    end
  end

endmodule

[hdl/ckd_parser.sv]
// Key parse state and the per-byte step of the composite key deframer.
// Uses ckd_pkg for the result struct and error codes.
module ckd_parser #(
  parameter int LENGTH_BITS = ckd_pkg::LENGTH_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    key_byte,
  input  logic          key_last,
  input  logic          composite_mode,
  output logic          res_vld,
  output ckd_pkg::res_t res
);

  localparam int LEN_BYTES = (LENGTH_BITS + 7) / 8;
  localparam int CNT_W     = (LEN_BYTES > 1) ? $clog2(LEN_BYTES) : 1;

  // Parse phase codes
  localparam logic [1:0] PH_LEN_FIRST = 2'd0;
  localparam logic [1:0] PH_LEN_MORE  = 2'd1;
  localparam logic [1:0] PH_DATA      = 2'd2;
  localparam logic [1:0] PH_MARKER    = 2'd3;

  logic [1:0]             phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] left_r, left_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   disc_r, disc_nxt;

  logic [LENGTH_BITS+7:0] len_shift;
  logic [LENGTH_BITS-1:0] len_val;
  logic [CNT_W-1:0]       cnt_val;
  logic                   len_done;
  logic [LENGTH_BITS-1:0] left_dec;

  // Assemble the length prefix big-endian; surplus high bits fall off
  assign len_shift = {left_r, key_byte};
  assign len_val   = (phase_r == PH_LEN_FIRST) ? LENGTH_BITS'(key_byte)
                                               : len_shift[LENGTH_BITS-1:0];
  assign cnt_val   = (phase_r == PH_LEN_FIRST) ? '0 : cnt_r + CNT_W'(1);
  assign len_done  = (cnt_val == CNT_W'(LEN_BYTES - 1));
  assign left_dec  = left_r - LENGTH_BITS'(1);

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    cnt_nxt   = cnt_r;
    disc_nxt  = disc_r;
    res_vld   = 1'b0;
    res       = '0;
    res.error_code = ckd_pkg::ERR_NONE;

    if (step) begin
      if (!composite_mode) begin
        // Single mode: pass every byte, close the key on its last byte
        res_vld           = 1'b1;
        res.data_byte     = key_byte;
        res.has_byte      = 1'b1;
        res.component_end = key_last;
        res.key_end       = key_last;
      end else if (!disc_r) begin
        unique case (phase_r)
          PH_LEN_FIRST, PH_LEN_MORE: begin
            if (key_last) begin
              res_vld        = 1'b1;
              res.error_code = ckd_pkg::ERR_TRUNCATED;
              res.key_end    = 1'b1;
            end else if (len_done) begin
              left_nxt  = len_val;
              cnt_nxt   = '0;
              phase_nxt = (len_val == '0) ? PH_MARKER : PH_DATA;
            end else begin
              left_nxt  = len_val;
              cnt_nxt   = cnt_val;
              phase_nxt = PH_LEN_MORE;
            end
          end
          PH_DATA: begin
            res_vld       = 1'b1;
            res.data_byte = key_byte;
            res.has_byte  = 1'b1;
            if (key_last) begin
              res.error_code = ckd_pkg::ERR_TRUNCATED;
              res.key_end    = 1'b1;
            end else begin
              left_nxt = left_dec;
              if (left_dec == '0) begin
                phase_nxt = PH_MARKER;
              end
            end
          end
          PH_MARKER: begin
            res_vld           = 1'b1;
            res.component_end = 1'b1;
            res.end_marker    = key_byte;
            res.key_end       = key_last;
            if (!key_last) begin
              phase_nxt = PH_LEN_FIRST;
              left_nxt  = '0;
              cnt_nxt   = '0;
              if (key_byte != 8'd0) begin
                res.error_code = ckd_pkg::ERR_BAD_MARK;
                disc_nxt       = 1'b1;
              end
            end
          end
          default: begin
            phase_nxt = PH_LEN_FIRST;
          end
        endcase
      end

      // Last byte of a key always returns to the start of a key
      if (key_last) begin
        phase_nxt = PH_LEN_FIRST;
        left_nxt  = '0;
        cnt_nxt   = '0;
        disc_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN_FIRST;
      left_r  <= '0;
      cnt_r   <= '0;
      disc_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      cnt_r   <= cnt_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule

[hdl/ckd_out_stage.sv]
// Result register of the composite key deframer: holds one result transaction.
// Uses ckd_pkg for the result struct.
module ckd_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  ckd_pkg::res_t res,
  output logic          free,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_data_byte,
  output logic          out_has_byte,
  output logic          out_component_end,
  output logic [7:0]    out_end_marker,
  output logic [1:0]    out_error_code,
  output logic          out_key_end
);

  logic          vld_r;
  ckd_pkg::res_t res_r;

  // Register can take a new result when empty or being read this cycle
  assign free = !vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (free) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res;
    end
  end

  assign out_valid         = vld_r;
  assign out_data_byte     = res_r.data_byte;
  assign out_has_byte      = res_r.has_byte;
  assign out_component_end = res_r.component_end;
  assign out_end_marker    = res_r.end_marker;
  assign out_error_code    = res_r.error_code;
  assign out_key_end       = res_r.key_end;

endmodule

[hdl/composite_key_deframer.sv]
// Composite key deframer: takes one key byte per cycle while not stalled and
// returns at most one result per byte. Every byte passes through an input
// register, one step of parse logic and a result register, so a byte can be
// accepted in every cycle while the output is not stalled, and its result is
// presented on the outputs from the result register until it is taken.
// The rate of one byte per clock, when not stalled, is set by the single parse
// step, whose state (phase, length, discard flag) is updated once per byte.
// Bytes that produce no result (length prefix, dropped bytes) still pass
// through the parse step. cfg_composite_mode selects composite (1, reset) or
// single mode (0) and must be written only while no key byte is in flight.
module composite_key_deframer #(
  parameter int LENGTH_BITS = ckd_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_write_en,
  input  logic       cfg_composite_mode,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_key_byte,
  input  logic       in_key_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_has_byte,
  output logic       out_component_end,
  output logic [7:0] out_end_marker,
  output logic [1:0] out_error_code,
  output logic       out_key_end
);

  logic          mode_r;
  logic          item_vld;
  logic [7:0]    item_byte;
  logic          item_last;
  logic          out_free;
  logic          advance;
  logic          res_vld;
  ckd_pkg::res_t res;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_write_en) begin
      mode_r <= cfg_composite_mode;
    end
  end

  // Move a held byte through the parser when the result register has room
  assign advance = item_vld && out_free;

  ckd_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_key_byte (in_key_byte),
    .in_key_last (in_key_last),
    .advance     (advance),
    .item_vld    (item_vld),
    .item_byte   (item_byte),
    .item_last   (item_last)
  );

  ckd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .key_byte       (item_byte),
    .key_last       (item_last),
    .composite_mode (mode_r),
    .res_vld        (res_vld),
    .res            (res)
  );

  ckd_out_stage u_out_stage (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (res_vld),
    .res               (res),
    .free              (out_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data_byte     (out_data_byte),
    .out_has_byte      (out_has_byte),
    .out_component_end (out_component_end),
    .out_end_marker    (out_end_marker),
    .out_error_code    (out_error_code),
    .out_key_end       (out_key_end)
  );

endmodule

[hdl/ckd_checker.sv]
// Port-level checks for the composite key deframer, bound to the top level.
// Uses the assertion macros from composite_key_deframer_macros.svh.
`include "composite_key_deframer_macros.svh"

module ckd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_data_byte,
  input logic       out_has_byte,
  input logic       out_component_end,
  input logic [7:0] out_end_marker,
  input logic [1:0] out_error_code,
  input logic       out_key_end
);

  // A result without a data byte carries a zero byte
  `CKD_ASSERT_IMPL(a_no_byte_zero, out_valid && !out_has_byte, out_data_byte == 8'd0)

  // A marker is only reported when a component closes
  `CKD_ASSERT_IMPL(a_marker_on_end, out_valid && !out_component_end, out_end_marker == 8'd0)

  // A bad marker closes a component mid key with a nonzero marker
  `CKD_ASSERT_IMPL(a_bad_marker, out_valid && out_error_code == ckd_pkg::ERR_BAD_MARK,
    out_component_end && !out_key_end && out_end_marker != 8'd0)

  // A truncated key ends the key without closing a component
  `CKD_ASSERT_IMPL(a_truncated, out_valid && out_error_code == ckd_pkg::ERR_TRUNCATED,
    out_key_end && !out_component_end)

  // A stalled result transaction holds
  `CKD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_data_byte) && $stable(out_end_marker))

endmodule

bind composite_key_deframer ckd_checker u_ckd_checker (.*);
